@@ hw/rtl/sha1md_pkg.sv @@
// Shared types, constants and round functions for the SHA-1 message digest.
// No dependencies; compiled first.
package sha1md_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 4;
  localparam int unsigned ROUNDS         = 80;
  localparam logic [7:0]  PAD_BYTE       = 8'h80;
  localparam logic [3:0]  LEN_WORD_POS   = 4'd14;

  localparam logic [31:0] H_INIT_0 = 32'h67452301;
  localparam logic [31:0] H_INIT_1 = 32'hEFCDAB89;
  localparam logic [31:0] H_INIT_2 = 32'h98BADCFE;
  localparam logic [31:0] H_INIT_3 = 32'h10325476;
  localparam logic [31:0] H_INIT_4 = 32'hC3D2E1F0;

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  // One word of the padded message, or the end marker of a message
  typedef struct packed {
    logic        fin;
    logic [31:0] word;
  } sha1md_op_t;

  typedef enum logic [2:0] {
    F_ACCEPT,
    F_PAD_FIRST,
    F_PAD_ZERO,
    F_LEN_HI,
    F_LEN_LO,
    F_FINISH
  } front_state_t;

  typedef enum logic [1:0] {
    B_LOAD,
    B_ROUND,
    B_ADD,
    B_OUT
  } back_state_t;

  function automatic logic [31:0] h_init(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = H_INIT_0;
      3'd1:    v = H_INIT_1;
      3'd2:    v = H_INIT_2;
      3'd3:    v = H_INIT_3;
      default: v = H_INIT_4;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] v;
    if (rnd < 7'd20)      v = K_0;
    else if (rnd < 7'd40) v = K_1;
    else if (rnd < 7'd60) v = K_2;
    else                  v = K_3;
    return v;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] v;
    if (rnd < 7'd20)                      v = (b & c) | (~b & d);
    else if (rnd < 7'd40 || rnd >= 7'd60) v = b ^ c ^ d;
    else                                  v = (b & c) | (b & d) | (c & d);
    return v;
  endfunction

endpackage

@@ hw/rtl/sha1md_if.sv @@
// Handshake channels of the SHA-1 message digest: byte input and digest output.
// Depends on nothing; compiled after sha1md_pkg.
interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, has_byte, data_byte, end_of_message, input ready);
  modport sink   (input valid, has_byte, data_byte, end_of_message, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_word;

  modport source (output valid, digest_word, word_index, final_word, input ready);
  modport sink   (input valid, digest_word, word_index, final_word, output ready);
endinterface

@@ hw/rtl/sha1_message_digest.sv @@
// SHA-1 message digest, top level: front end, operation queue and compression back end.
// Depends on sha1md_pkg, sha1md_if, sha1md_front, sha1md_fifo, sha1md_back.
//
// Feed the message one byte beat at a time on in_chan (has_byte set); mark the
// last beat with end_of_message, which may carry a byte or none, so an empty
// message is hashed by a lone end beat. A beat with neither flag is taken and
// ignored. After the end beat the block pads the message, appends the 64-bit
// bit count (wrapping at 2^64) and returns the five digest words on out_chan,
// H0 first, word_index 0 to 4, final_word set on the last; it then starts a
// fresh message by itself. The front end packs bytes into words and takes one
// beat per cycle until the queue between the two halves fills. While the back
// end runs the 80 rounds and the chaining add, the front with the default
// queue of four words takes only 16 bytes and then stalls, and the other 48
// bytes of the block follow at one per cycle while the back end shifts words
// into its schedule line. The end beat adds the padding words, one or two
// extra compressions and five output beats. The output beat sits in its own
// register, so the front keeps taking bytes of the next message, until the
// queue fills, while the digest waits to be taken.
module sha1_message_digest
  import sha1md_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sha1md_in_if.sink    in_chan,
  sha1md_out_if.source out_chan
);

  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;
  sha1md_op_t push_op, pop_op;

  // Bytes in, padded word stream out
  sha1md_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  // Decouple packing from compression
  sha1md_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  // Rounds and digest output
  sha1md_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .out_chan  (out_chan)
  );

endmodule

@@ hw/rtl/sha1md_fifo.sv @@
// Short operation queue between the packing front end and the compression back end.
// Depends on sha1md_pkg.
module sha1md_fifo
  import sha1md_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  sha1md_op_t push_op,
  output logic       pop_valid,
  input  logic       pop_ready,
  output sha1md_op_t pop_op
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sha1md_op_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_op;
  end

endmodule

@@ hw/rtl/sha1md_front.sv @@
// Front end: takes byte beats, packs them big-endian into words, counts the
// message length and emits the padding and length words. Depends on sha1md_pkg, sha1md_if.
module sha1md_front
  import sha1md_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sha1md_in_if.sink   in_chan,
  output logic        push_valid,
  input  logic        push_ready,
  output sha1md_op_t  push_op
);

  front_state_t state_r, state_nxt;
  logic [31:0]  acc_r, acc_nxt;
  logic [5:0]   pos_r, pos_nxt;        // bytes held in the current block
  logic [60:0]  cnt_r, cnt_nxt;        // message length in bytes, mod 2^61
  logic [3:0]   wcnt_r, wcnt_nxt;      // word position during padding
  logic         extra_r, extra_nxt;    // length does not fit: one more block
  logic [31:0]  byte_word, pad_word;

  assign byte_word = {24'b0, in_chan.data_byte} << {~pos_r[1:0], 3'b000};
  assign pad_word  = (pos_r[1:0] == 2'd0) ? {PAD_BYTE, 24'b0}
                   : (acc_r | ({24'b0, PAD_BYTE} << {~pos_r[1:0], 3'b000}));

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    wcnt_nxt      = wcnt_r;
    extra_nxt     = extra_r;
    push_valid    = 1'b0;
    push_op       = '0;
    in_chan.ready = 1'b0;
    case (state_r)
      F_ACCEPT: begin
        in_chan.ready = push_ready;
        if (in_chan.valid && push_ready) begin
          if (in_chan.has_byte) begin
            acc_nxt = (pos_r[1:0] == 2'd0) ? byte_word : (acc_r | byte_word);
            pos_nxt = pos_r + 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            if (pos_r[1:0] == 2'd3) begin
              push_valid   = 1'b1;
              push_op.word = acc_nxt;
            end
          end
          if (in_chan.end_of_message) state_nxt = F_PAD_FIRST;
        end
      end
      F_PAD_FIRST: begin
        push_valid   = 1'b1;
        push_op.word = pad_word;
        if (push_ready) begin
          wcnt_nxt  = pos_r[5:2] + 1'b1;
          extra_nxt = (pos_r[5:2] == LEN_WORD_POS);
          state_nxt = F_PAD_ZERO;
        end
      end
      F_PAD_ZERO: begin
        if (wcnt_r == LEN_WORD_POS && !extra_r) begin
          state_nxt = F_LEN_HI;
        end else begin
          push_valid = 1'b1;
          if (push_ready) begin
            wcnt_nxt = wcnt_r + 1'b1;
            if (wcnt_r == 4'd15) extra_nxt = 1'b0;
          end
        end
      end
      F_LEN_HI: begin
        push_valid   = 1'b1;
        push_op.word = cnt_r[60:29];
        if (push_ready) state_nxt = F_LEN_LO;
      end
      F_LEN_LO: begin
        push_valid   = 1'b1;
        push_op.word = {cnt_r[28:0], 3'b000};
        if (push_ready) state_nxt = F_FINISH;
      end
      F_FINISH: begin
        push_valid  = 1'b1;
        push_op.fin = 1'b1;
        if (push_ready) begin
          pos_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = F_ACCEPT;
        end
      end
      default: state_nxt = F_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_ACCEPT;
      pos_r   <= '0;
      cnt_r   <= '0;
      wcnt_r  <= '0;
      extra_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      wcnt_r  <= wcnt_nxt;
      extra_r <= extra_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

@@ hw/rtl/sha1md_back.sv @@
// Back end: gathers sixteen words into the schedule shift line, runs the 80
// rounds one per cycle and emits the digest words. Depends on sha1md_pkg, sha1md_if.
module sha1md_back
  import sha1md_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  sha1md_op_t  pop_op,
  sha1md_out_if.source out_chan
);

  back_state_t state_r, state_nxt;
  logic [31:0] h_r [5];
  logic [31:0] h_nxt [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] sched_r [16];
  logic [31:0] sched_nxt [16];
  logic [3:0]  wcnt_r, wcnt_nxt;
  logic [6:0]  round_r, round_nxt;
  logic [2:0]  k_r, k_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic [31:0] t_sum, w_new, w_xor;

  assign w_xor = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
  assign w_new = {w_xor[30:0], w_xor[31]};
  assign t_sum = {a_r[26:0], a_r[31:27]} + round_f(round_r, b_r, c_r, d_r) + e_r
               + round_k(round_r) + sched_r[0];

  assign pop_ready            = (state_r == B_LOAD);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.digest_word = out_word_r;
  assign out_chan.word_index  = out_idx_r;
  assign out_chan.final_word  = (out_idx_r == LAST_WORD_IDX);

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    sched_nxt     = sched_r;
    wcnt_nxt      = wcnt_r;
    round_nxt     = round_r;
    k_nxt         = k_r;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      B_LOAD: begin
        if (pop_valid) begin
          if (pop_op.fin) begin
            k_nxt     = '0;
            state_nxt = B_OUT;
          end else begin
            for (int i = 0; i < 15; i++) sched_nxt[i] = sched_r[i + 1];
            sched_nxt[15] = pop_op.word;
            wcnt_nxt      = wcnt_r + 1'b1;
            if (wcnt_r == 4'd15) begin
              a_nxt     = h_r[0];
              b_nxt     = h_r[1];
              c_nxt     = h_r[2];
              d_nxt     = h_r[3];
              e_nxt     = h_r[4];
              round_nxt = '0;
              state_nxt = B_ROUND;
            end
          end
        end
      end
      B_ROUND: begin
        a_nxt = t_sum;
        b_nxt = a_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        d_nxt = c_r;
        e_nxt = d_r;
        for (int i = 0; i < 15; i++) sched_nxt[i] = sched_r[i + 1];
        sched_nxt[15] = w_new;
        round_nxt     = round_r + 1'b1;
        if (round_r == 7'(ROUNDS - 1)) state_nxt = B_ADD;
      end
      B_ADD: begin
        h_nxt[0]  = h_r[0] + a_r;
        h_nxt[1]  = h_r[1] + b_r;
        h_nxt[2]  = h_r[2] + c_r;
        h_nxt[3]  = h_r[3] + d_r;
        h_nxt[4]  = h_r[4] + e_r;
        state_nxt = B_LOAD;
      end
      B_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = h_r[k_r];
          out_idx_nxt   = k_r;
          k_nxt         = k_r + 1'b1;
          if (k_r == LAST_WORD_IDX) begin
            for (int i = 0; i < 5; i++) h_nxt[i] = h_init(3'(i));
            state_nxt = B_LOAD;
          end
        end
      end
      default: state_nxt = B_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_LOAD;
      wcnt_r      <= '0;
      round_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 5; i++) h_r[i] <= h_init(3'(i));
    end else begin
      state_r     <= state_nxt;
      wcnt_r      <= wcnt_nxt;
      round_r     <= round_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      h_r         <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    e_r        <= e_nxt;
    sched_r    <= sched_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
  end

endmodule
